FILE: hdl/tbik_pkg.sv
`default_nettype none
package tbik_pkg;

  localparam int DEFAULT_COORD_WIDTH  = 16;
  localparam int DEFAULT_ANGLE_WIDTH  = 16;
  localparam int DEFAULT_CORDIC_STEPS = 16;

  localparam int LEN_W      = 15;
  localparam int TOL_W      = 16;
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [REG_IDX_W-1:0] REG_FIRST_LENGTH    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_LENGTH   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_EQUAL_TOLERANCE = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = 15'd256;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;
  localparam int               EPS_RAW   = 6;

  localparam logic [1:0] CLASS_DIV = 2'd0;
  localparam logic [1:0] CLASS_POS = 2'd1;
  localparam logic [1:0] CLASS_NEG = 2'd2;

  localparam int VEC_W         = 60;
  localparam int NORM_N        = 7;
  localparam int NORM_EXP      = 55;
  localparam int CORDIC_FIXED  = NORM_N + 2;
  localparam int ATAN_LEN      = 24;

  localparam logic [31:0] Z_PI       = 32'h8000_0000;
  localparam logic [31:0] Z_HALF     = 32'h4000_0000;
  localparam logic [31:0] Z_NEG_HALF = 32'hC000_0000;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  function automatic int norm_shift(input int j);
    return (j < NORM_N - 1) ? (32 >> j) : 1;
  endfunction

  function automatic int norm_limit(input int j);
    return (j < NORM_N - 1) ? (NORM_EXP - (32 >> j)) : NORM_EXP;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/tbik_if.sv
`default_nettype none
interface tbik_in_if #(
  parameter int COORD_WIDTH = tbik_pkg::DEFAULT_COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] target_x;
  logic signed [COORD_WIDTH-1:0] target_y;
  logic                          bend_positive;

  modport source (output valid, target_x, target_y, bend_positive, input ready);
  modport sink (input valid, target_x, target_y, bend_positive, output ready);
endinterface

interface tbik_out_if #(
  parameter int ANGLE_WIDTH = tbik_pkg::DEFAULT_ANGLE_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angle_first;
  logic signed [ANGLE_WIDTH-1:0] angle_second;
  logic signed [ANGLE_WIDTH-1:0] other_angle_first;
  logic signed [ANGLE_WIDTH-1:0] other_angle_second;
  logic                          reachable;

  modport source (output valid, angle_first, angle_second, other_angle_first,
                  other_angle_second, reachable, input ready);
  modport sink (input valid, angle_first, angle_second, other_angle_first,
                other_angle_second, reachable, output ready);
endinterface
`default_nettype wire

FILE: hdl/tbik_cordic.sv
`default_nettype none
module tbik_cordic #(
  parameter int STEPS = tbik_pkg::DEFAULT_CORDIC_STEPS
) (
  input  wire logic                             clk_i,
  input  wire logic                             en_i,
  input  wire logic signed [tbik_pkg::VEC_W-1:0] x_i,
  input  wire logic signed [tbik_pkg::VEC_W-1:0] y_i,
  output logic [31:0]                           z_o
);
  import tbik_pkg::*;

  logic signed [VEC_W-1:0] ax, ay;
  logic                    sp_d;
  logic [31:0]             spz_d;

  logic signed [VEC_W-1:0] ex_q, ey_q;
  logic [VEC_W-1:0]        em_q;
  logic                    esp_q;
  logic [31:0]             espz_q;

  always_comb begin
    ax    = x_i[VEC_W-1] ? -x_i : x_i;
    ay    = y_i[VEC_W-1] ? -y_i : y_i;
    sp_d  = (y_i == '0) || (x_i == '0);
    if (y_i == '0) begin
      spz_d = x_i[VEC_W-1] ? Z_PI : '0;
    end else begin
      spz_d = (y_i > 0) ? Z_HALF : Z_NEG_HALF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q   <= x_i;
      ey_q   <= y_i;
      em_q   <= (ax > ay) ? ax : ay;
      esp_q  <= sp_d;
      espz_q <= spz_d;
    end
  end

  logic signed [VEC_W-1:0] nx_q [NORM_N];
  logic signed [VEC_W-1:0] ny_q [NORM_N];
  logic [VEC_W-1:0]        nm_q [NORM_N];
  logic                    nsp_q [NORM_N];
  logic [31:0]             nspz_q [NORM_N];

  for (genvar j = 0; j < NORM_N; j++) begin : g_norm
    localparam int SH = norm_shift(j);
    localparam int TH = norm_limit(j);
    logic signed [VEC_W-1:0] px, py;
    logic [VEC_W-1:0]        pm;
    logic                    psp;
    logic [31:0]             pspz;
    if (j == 0) begin : g_src
      assign px = ex_q; assign py = ey_q; assign pm = em_q;
      assign psp = esp_q; assign pspz = espz_q;
    end else begin : g_src
      assign px = nx_q[j-1]; assign py = ny_q[j-1]; assign pm = nm_q[j-1];
      assign psp = nsp_q[j-1]; assign pspz = nspz_q[j-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ((pm >> TH) == '0) begin
          nx_q[j] <= px <<< SH;
          ny_q[j] <= py <<< SH;
          nm_q[j] <= pm << SH;
        end else begin
          nx_q[j] <= px;
          ny_q[j] <= py;
          nm_q[j] <= pm;
        end
        nsp_q[j]  <= psp;
        nspz_q[j] <= pspz;
      end
    end
  end

  logic signed [VEC_W-1:0] fx_q, fy_q;
  logic [31:0]             fz_q, fspz_q;
  logic                    fsp_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (nx_q[NORM_N-1][VEC_W-1]) begin
        fx_q <= -nx_q[NORM_N-1];
        fy_q <= -ny_q[NORM_N-1];
        fz_q <= Z_PI;
      end else begin
        fx_q <= nx_q[NORM_N-1];
        fy_q <= ny_q[NORM_N-1];
        fz_q <= '0;
      end
      fsp_q  <= nsp_q[NORM_N-1];
      fspz_q <= nspz_q[NORM_N-1];
    end
  end

  logic signed [VEC_W-1:0] cx_q [STEPS];
  logic signed [VEC_W-1:0] cy_q [STEPS];
  logic [31:0]             cz_q [STEPS];
  logic                    csp_q [STEPS];
  logic [31:0]             cspz_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [VEC_W-1:0] px, py;
    logic [31:0]             pz, pspz;
    logic                    psp;
    if (i == 0) begin : g_src
      assign px = fx_q; assign py = fy_q; assign pz = fz_q;
      assign psp = fsp_q; assign pspz = fspz_q;
    end else begin : g_src
      assign px = cx_q[i-1]; assign py = cy_q[i-1]; assign pz = cz_q[i-1];
      assign psp = csp_q[i-1]; assign pspz = cspz_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (py > 0) begin
          cx_q[i] <= px + (py >>> i);
          cy_q[i] <= py - (px >>> i);
          cz_q[i] <= pz + ATAN_TAB[i];
        end else begin
          cx_q[i] <= px - (py >>> i);
          cy_q[i] <= py + (px >>> i);
          cz_q[i] <= pz - ATAN_TAB[i];
        end
        csp_q[i]  <= psp;
        cspz_q[i] <= pspz;
      end
    end
  end

  assign z_o = csp_q[STEPS-1] ? cspz_q[STEPS-1] : cz_q[STEPS-1];

endmodule
`default_nettype wire

FILE: hdl/two_bone_ik_solver.sv
`default_nettype none
// Planar two-bone inverse kinematics: for each target item (x, y, bend) it returns root
// and elbow angles for the chosen and the opposite bend plus a reachability flag. Bone
// lengths and the zero-length tolerance are written on the cfg port; the user must do so
// only while no item is in flight, which the block does not enforce. The pipeline takes
// one item every cycle and stalls as a whole when the result register is full and not
// taken. Between acceptance and result lie four front stages, a 31-stage bit-per-stage
// divider for the elbow cosine, two stages to square it, a 31-stage bit-per-stage square
// root for the sine, four stages for the rotated vectors, three parallel CORDIC vectoring
// pipelines of 9 + CORDIC_STEPS stages each, and the result register.
module two_bone_ik_solver #(
  parameter int COORD_WIDTH  = tbik_pkg::DEFAULT_COORD_WIDTH,
  parameter int ANGLE_WIDTH  = tbik_pkg::DEFAULT_ANGLE_WIDTH,
  parameter int CORDIC_STEPS = tbik_pkg::DEFAULT_CORDIC_STEPS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [tbik_pkg::REG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tbik_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tbik_in_if.sink                              in_item_i,
  tbik_out_if.source                           out_item_o
);
  import tbik_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int LW    = LEN_W;
  localparam int DW    = 2 * CW;
  localparam int SQW   = 2 * LW;
  localparam int DENW  = 2 * LW + 1;
  localparam int SUMW  = 2 * LW + 2;
  localparam int WW    = ((DW > SUMW) ? DW : SUMW) + 1;
  localparam int RW    = 32;
  localparam int QW    = 31;
  localparam int CVW   = 32;
  localparam int DIV_N = QW;
  localparam int NSQ   = 61;
  localparam int SQ_N  = 31;
  localparam int MW    = 48;
  localparam int AJW   = 26;
  localparam int PW    = CW + AJW;
  localparam int CL    = CORDIC_FIXED + CORDIC_STEPS;
  localparam logic [31:0]    RND   = 32'(1) << (31 - ANGLE_WIDTH);
  localparam logic [NSQ-1:0] SQONE = NSQ'(1) << (NSQ - 1);

  typedef struct packed {
    logic signed [CW-1:0] tx;
    logic signed [CW-1:0] ty;
    logic                 pos;
    logic                 reach;
    logic [1:0]           code;
  } ctx_t;

  logic en;
  logic out_valid_q;

  assign en              = !out_valid_q || out_item_o.ready;
  assign in_item_i.ready = en;

  logic [LW-1:0]    len1_q, len2_q;
  logic [TOL_W-1:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len1_q <= LEN_RESET;
      len2_q <= LEN_RESET;
      tol_q  <= TOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIRST_LENGTH:    len1_q <= cfg_data_i[LW-1:0];
        REG_SECOND_LENGTH:   len2_q <= cfg_data_i[LW-1:0];
        REG_EQUAL_TOLERANCE: tol_q  <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SQW-1:0]  l1sq_q, l2sq_q, l12_q;
  logic [SUMW-1:0] sum_q, lsq_q, dif_q;
  logic [DENW-1:0] den_q;
  logic            degen_q;

  always_ff @(posedge clk_i) begin
    l1sq_q  <= SQW'(len1_q) * SQW'(len1_q);
    l2sq_q  <= SQW'(len2_q) * SQW'(len2_q);
    l12_q   <= SQW'(len1_q) * SQW'(len2_q);
    lsq_q   <= SUMW'(l1sq_q) + SUMW'(l2sq_q);
    sum_q   <= SUMW'(l1sq_q) + SUMW'(l2sq_q) + SUMW'({l12_q, 1'b0});
    dif_q   <= SUMW'(l1sq_q) + SUMW'(l2sq_q) - SUMW'({l12_q, 1'b0});
    den_q   <= {l12_q, 1'b0};
    degen_q <= {l12_q, 1'b0} <= DENW'(EPS_RAW);
  end

  // front stages
  logic                 v1_q, v2_q, v3_q, v4_q;
  ctx_t                 c1_q, c2_q, c3_q, c4_q;
  logic [DW-1:0]        sqx2_q, sqy2_q, d2_3_q;
  logic [RW-1:0]        r4_q;
  logic                 neg4_q;
  logic signed [DW-1:0] txe, tye;

  assign txe = DW'(c1_q.tx);
  assign tye = DW'(c1_q.ty);

  logic signed [WW-1:0] d2w, num, absnum, diffd, absd;
  logic                 far, near, dreach;
  ctx_t                 c4_d;

  always_comb begin
    d2w    = WW'(d2_3_q);
    far    = d2w > WW'(sum_q);
    near   = d2w < WW'(dif_q);
    num    = d2w - WW'(lsq_q);
    absnum = num[WW-1] ? -num : num;
    diffd  = d2w - WW'(sum_q);
    absd   = diffd[WW-1] ? -diffd : diffd;
    dreach = absd <= WW'(tol_q);
    c4_d   = c3_q;
    priority if (degen_q) begin
      c4_d.code  = CLASS_POS;
      c4_d.reach = dreach;
    end else if (far) begin
      c4_d.code  = CLASS_POS;
      c4_d.reach = 1'b0;
    end else if (near) begin
      c4_d.code  = CLASS_NEG;
      c4_d.reach = 1'b0;
    end else begin
      c4_d.code  = CLASS_DIV;
      c4_d.reach = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_item_i.valid; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q.tx    <= in_item_i.target_x;
      c1_q.ty    <= in_item_i.target_y;
      c1_q.pos   <= in_item_i.bend_positive;
      c1_q.reach <= 1'b0;
      c1_q.code  <= CLASS_DIV;
      c2_q       <= c1_q;
      sqx2_q     <= txe * txe;
      sqy2_q     <= tye * tye;
      c3_q       <= c2_q;
      d2_3_q     <= sqx2_q + sqy2_q;
      c4_q       <= c4_d;
      r4_q       <= RW'(absnum);
      neg4_q     <= num[WW-1];
    end
  end

  // elbow cosine divider, one quotient bit a stage
  logic          dv_q   [DIV_N];
  ctx_t          dctx_q [DIV_N];
  logic [RW-1:0] dr_q   [DIV_N];
  logic [QW-1:0] dq_q   [DIV_N];
  logic          dneg_q [DIV_N];

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    logic          pv, pneg, ge;
    ctx_t          pctx;
    logic [RW-1:0] rs;
    logic [QW-1:0] pq;
    if (k == 0) begin : g_src
      assign pv = v4_q; assign pctx = c4_q; assign pneg = neg4_q;
      assign rs = r4_q; assign pq = '0;
    end else begin : g_src
      assign pv = dv_q[k-1]; assign pctx = dctx_q[k-1]; assign pneg = dneg_q[k-1];
      assign rs = dr_q[k-1] << 1; assign pq = dq_q[k-1];
    end
    assign ge = rs >= RW'(den_q);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else if (en) begin
        dv_q[k] <= pv;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dctx_q[k] <= pctx;
        dneg_q[k] <= pneg;
        dr_q[k]   <= ge ? rs - RW'(den_q) : rs;
        dq_q[k]   <= {pq[QW-2:0], ge};
      end
    end
  end

  logic                  v5_q, v6_q;
  ctx_t                  c5_q, c6_q;
  logic signed [CVW-1:0] cos5_q, cos6_q, qv, cos5_d;
  logic [NSQ-1:0]        csq6_q;
  logic signed [NSQ:0]   cse;

  always_comb begin
    qv = CVW'(dq_q[DIV_N-1]);
    unique case (dctx_q[DIV_N-1].code)
      CLASS_DIV: cos5_d = dneg_q[DIV_N-1] ? -qv : qv;
      CLASS_POS: cos5_d = CVW'(1) <<< 30;
      CLASS_NEG: cos5_d = -(CVW'(1) <<< 30);
      default:   cos5_d = CVW'(1) <<< 30;
    endcase
  end

  assign cse = (NSQ + 1)'(cos5_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0; v6_q <= 1'b0;
    end else if (en) begin
      v5_q <= dv_q[DIV_N-1]; v6_q <= v5_q;
    end
  end

  logic signed [NSQ:0] csq_full;
  assign csq_full = cse * cse;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c5_q   <= dctx_q[DIV_N-1];
      cos5_q <= cos5_d;
      c6_q   <= c5_q;
      cos6_q <= cos5_q;
      csq6_q <= csq_full[NSQ-1:0];
    end
  end

  // sine by digit-recurrence square root, one result bit a stage
  logic                  sv_q   [SQ_N];
  ctx_t                  sctx_q [SQ_N];
  logic signed [CVW-1:0] scos_q [SQ_N];
  logic [NSQ-1:0]        sn_q   [SQ_N];
  logic [NSQ-1:0]        sres_q [SQ_N];

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    localparam logic [NSQ-1:0] BITV = NSQ'(1) << (NSQ - 1 - 2 * i);
    logic                  pv;
    ctx_t                  pctx;
    logic signed [CVW-1:0] pcos;
    logic [NSQ-1:0]        pn, pres;
    logic [NSQ:0]          t;
    logic                  ge;
    if (i == 0) begin : g_src
      assign pv = v6_q; assign pctx = c6_q; assign pcos = cos6_q;
      assign pn = SQONE - csq6_q; assign pres = '0;
    end else begin : g_src
      assign pv = sv_q[i-1]; assign pctx = sctx_q[i-1]; assign pcos = scos_q[i-1];
      assign pn = sn_q[i-1]; assign pres = sres_q[i-1];
    end
    assign t  = {1'b0, pres} + {1'b0, BITV};
    assign ge = {1'b0, pn} >= t;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[i] <= 1'b0;
      end else if (en) begin
        sv_q[i] <= pv;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sctx_q[i] <= pctx;
        scos_q[i] <= pcos;
        sn_q[i]   <= ge ? pn - t[NSQ-1:0] : pn;
        sres_q[i] <= ge ? (pres >> 1) + BITV : pres >> 1;
      end
    end
  end

  // rotated target vectors
  logic                  v7_q, v8_q, v9_q, v10_q;
  ctx_t                  c7_q, c8_q, c9_q;
  logic signed [CVW-1:0] cos7_q, cos8_q, cos9_q;
  logic [QW-1:0]         sin7_q, sin8_q, sin9_q;
  logic signed [MW-1:0]  l2e, cme, sme, ml2c7_q, ml2s7_q;
  logic signed [AJW-1:0] adj8_q, opp8_q;
  logic signed [PW-1:0]  txa9_q, tyo9_q, tya9_q, txo9_q;
  logic signed [VEC_W-1:0] xp_q, yp_q, xn_q, yn_q, ex_q, ey_q;
  logic                  pos10_q, reach10_q;

  assign l2e = MW'(len2_q);
  assign cme = MW'(scos_q[SQ_N-1]);
  assign sme = MW'(sres_q[SQ_N-1][QW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0;
    end else if (en) begin
      v7_q <= sv_q[SQ_N-1]; v8_q <= v7_q; v9_q <= v8_q; v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c7_q      <= sctx_q[SQ_N-1];
      cos7_q    <= scos_q[SQ_N-1];
      sin7_q    <= sres_q[SQ_N-1][QW-1:0];
      ml2c7_q   <= l2e * cme;
      ml2s7_q   <= l2e * sme;
      c8_q      <= c7_q;
      cos8_q    <= cos7_q;
      sin8_q    <= sin7_q;
      adj8_q    <= AJW'({len1_q, 8'b0}) + AJW'(ml2c7_q >>> 22);
      opp8_q    <= AJW'(ml2s7_q >>> 22);
      c9_q      <= c8_q;
      cos9_q    <= cos8_q;
      sin9_q    <= sin8_q;
      txa9_q    <= PW'(c8_q.tx) * PW'(adj8_q);
      tyo9_q    <= PW'(c8_q.ty) * PW'(opp8_q);
      tya9_q    <= PW'(c8_q.ty) * PW'(adj8_q);
      txo9_q    <= PW'(c8_q.tx) * PW'(opp8_q);
      xp_q      <= VEC_W'(txa9_q) + VEC_W'(tyo9_q);
      yp_q      <= VEC_W'(tya9_q) - VEC_W'(txo9_q);
      xn_q      <= VEC_W'(txa9_q) - VEC_W'(tyo9_q);
      yn_q      <= VEC_W'(tya9_q) + VEC_W'(txo9_q);
      ex_q      <= VEC_W'(cos9_q);
      ey_q      <= VEC_W'(sin9_q);
      pos10_q   <= c9_q.pos;
      reach10_q <= c9_q.reach;
    end
  end

  logic [31:0] zp, zn, ze, zne;

  tbik_cordic #(.STEPS(CORDIC_STEPS)) u_root_pos (
    .clk_i(clk_i), .en_i(en), .x_i(xp_q), .y_i(yp_q), .z_o(zp)
  );
  tbik_cordic #(.STEPS(CORDIC_STEPS)) u_root_neg (
    .clk_i(clk_i), .en_i(en), .x_i(xn_q), .y_i(yn_q), .z_o(zn)
  );
  tbik_cordic #(.STEPS(CORDIC_STEPS)) u_elbow (
    .clk_i(clk_i), .en_i(en), .x_i(ex_q), .y_i(ey_q), .z_o(ze)
  );

  assign zne = 32'd0 - ze;

  logic kv_q     [CL];
  logic kpos_q   [CL];
  logic kreach_q [CL];

  for (genvar k = 0; k < CL; k++) begin : g_side
    logic pv, ppos, preach;
    if (k == 0) begin : g_src
      assign pv = v10_q; assign ppos = pos10_q; assign preach = reach10_q;
    end else begin : g_src
      assign pv = kv_q[k-1]; assign ppos = kpos_q[k-1]; assign preach = kreach_q[k-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        kv_q[k] <= 1'b0;
      end else if (en) begin
        kv_q[k] <= pv;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        kpos_q[k]   <= ppos;
        kreach_q[k] <= preach;
      end
    end
  end

  function automatic logic [ANGLE_WIDTH-1:0] to_angle(input logic [31:0] z);
    logic [31:0] t;
    t = z + RND;
    return t[31 -: ANGLE_WIDTH];
  endfunction

  logic [ANGLE_WIDTH-1:0] rp, rn, re, rne;
  logic [ANGLE_WIDTH-1:0] af_q, as_q, oaf_q, oas_q;
  logic                   reach_q;

  assign rp  = to_angle(zp);
  assign rn  = to_angle(zn);
  assign re  = to_angle(ze);
  assign rne = to_angle(zne);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= kv_q[CL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      af_q    <= kpos_q[CL-1] ? rp : rn;
      as_q    <= kpos_q[CL-1] ? re : rne;
      oaf_q   <= kpos_q[CL-1] ? rn : rp;
      oas_q   <= kpos_q[CL-1] ? rne : re;
      reach_q <= kreach_q[CL-1];
    end
  end

  assign out_item_o.valid              = out_valid_q;
  assign out_item_o.angle_first        = af_q;
  assign out_item_o.angle_second       = as_q;
  assign out_item_o.other_angle_first  = oaf_q;
  assign out_item_o.other_angle_second = oas_q;
  assign out_item_o.reachable          = reach_q;

endmodule
`default_nettype wire

FILE: hdl/tbik_checker.sv
`default_nettype none
module tbik_checker #(
  parameter int ANGLE_WIDTH = tbik_pkg::DEFAULT_ANGLE_WIDTH
) (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_ready_i,
  input wire logic                   out_valid_i,
  input wire logic                   out_ready_i,
  input wire logic [ANGLE_WIDTH-1:0] angle_second_i,
  input wire logic [ANGLE_WIDTH-1:0] other_angle_second_i,
  input wire logic                   reachable_i
);
  localparam logic [ANGLE_WIDTH-1:0] HALF_TURN = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);

  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow the result register");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_clamped_elbow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !reachable_i && (in_valid_i || !in_valid_i) |->
      (angle_second_i == '0 || angle_second_i == HALF_TURN) &&
      (other_angle_second_i == '0 || other_angle_second_i == HALF_TURN))
    else $error("clamped item with an elbow angle other than zero or a half turn");

endmodule

bind two_bone_ik_solver tbik_checker #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_tbik_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_item_i.valid),
  .in_ready_i          (in_item_i.ready),
  .out_valid_i         (out_item_o.valid),
  .out_ready_i         (out_item_o.ready),
  .angle_second_i      (out_item_o.angle_second),
  .other_angle_second_i(out_item_o.other_angle_second),
  .reachable_i         (out_item_o.reachable)
);
`default_nettype wire
